@@ rtl/hff_pkg.sv @@
// ----------------------------------------------------------------------------
// hff_pkg
// Shared types, character codes and the digit lookup for the hex field
// formatter and its port checker.
// ----------------------------------------------------------------------------
package hff_pkg;

  // ASCII codes used by the formatter
  localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CHAR_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CHAR_X_UP  = 8'h58;  // 'X'
  localparam logic [7:0] CHAR_X_LO  = 8'h78;  // 'x'
  localparam logic [7:0] CHAR_A_UP  = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_A_LO  = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CHAR_F_UP  = 8'h46;  // 'F'
  localparam logic [7:0] CHAR_F_LO  = 8'h66;  // 'f'

  // Sequencer phases, one-hot
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_SETUP = 9'b000000010,
    ST_SIZE  = 9'b000000100,
    ST_LEAD  = 9'b000001000,
    ST_PFX   = 9'b000010000,
    ST_ZPAD  = 9'b000100000,
    ST_ZERO  = 9'b001000000,
    ST_DIGIT = 9'b010000000,
    ST_TRAIL = 9'b100000000
  } state_e;

  // One hex nibble to its ASCII digit
  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
    logic [7:0] base;
    base = upper ? CHAR_A_UP : CHAR_A_LO;
    if (nib < 4'd10) begin
      hex_char = CHAR_ZERO + {4'd0, nib};
    end else begin
      hex_char = base + {4'd0, nib - 4'd10};
    end
  endfunction

endpackage

@@ rtl/hex_field_formatter.sv @@
// ----------------------------------------------------------------------------
// hex_field_formatter
// Formats one 32-bit unsigned value as a printf %x / %X field and streams
// the characters out one request per character.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one value with its flags.
//   Output channel (out_valid_o / out_stall_i) returns the field characters
//   in order, last_char_o marking the final one. A field of zero length
//   (zero value, precision zero, width zero) returns nothing.
// Timing:
//   The block works on one request at a time; in_stall_o stays high from
//   the cycle after acceptance until the last character has been loaded
//   into the output register. The ST_SETUP and ST_SIZE states size the
//   field, then the characters come from two down counters (segment and
//   remaining) and a 32-bit digit shifter that moves up a nibble per digit;
//   the sequencer also steps past each segment ahead of the one holding
//   the last character (at most five). A field holds N <= MAX_CHARS
//   characters.
// Reset:
//   rst_ni clears the sequencer and the output valid; no request is lost
//   other than one in flight.
// Stall:
//   A stalled character holds in the output register; the sequencer waits
//   until the register frees up.
// ----------------------------------------------------------------------------
module hex_field_formatter #(
  parameter int MAX_CHARS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request in
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] value_i,
  input  logic        upper_case_i,
  input  logic        alt_form_i,
  input  logic        left_justify_i,
  input  logic        zero_pad_i,
  input  logic        has_precision_i,
  input  logic [5:0]  precision_i,
  input  logic [6:0]  field_width_i,
  // characters out
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_char_o,
  output logic        last_char_o
);

  localparam int CW = $clog2(MAX_CHARS + 1);
  localparam logic [6:0] PREC_MAX = 7'(MAX_CHARS - 2);
  localparam logic [6:0] WID_MAX  = 7'(MAX_CHARS);

  hff_pkg::state_e state_q, state_d;

  logic [31:0]   val_q;
  logic          upper_q, alt_q, left_q, zp_q, hp_q;
  logic [CW-1:0] prec_q, wid_q;
  logic [3:0]    ndig_q, ndig_d;
  logic          pre_q, pre_d;
  logic [CW-1:0] zeros_q, zeros_d;
  logic [CW-1:0] body_q, body_d;
  logic [CW-1:0] pad_q, pad_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [31:0]   dig_q, dig_d;

  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_char_q, out_char_d;
  logic          out_last_q, out_last_d;

  logic          in_acc;
  logic          out_free;
  logic          zpad_eff;
  logic [6:0]    prec_ext, wid_ext;
  logic [3:0]    shift_nib;
  logic          emit;
  logic [7:0]    emit_char;

  assign in_acc   = in_valid_i && (state_q == hff_pkg::ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign zpad_eff = !left_q && zp_q && !hp_q;

  // Clamp precision and width on capture
  assign prec_ext = has_precision_i ? {1'b0, precision_i} : 7'd0;
  assign wid_ext  = field_width_i;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      val_q   <= value_i;
      upper_q <= upper_case_i;
      alt_q   <= alt_form_i;
      left_q  <= left_justify_i;
      zp_q    <= zero_pad_i;
      hp_q    <= has_precision_i;
      prec_q  <= CW'((prec_ext > PREC_MAX) ? PREC_MAX : prec_ext);
      wid_q   <= CW'((wid_ext > WID_MAX) ? WID_MAX : wid_ext);
    end
  end

  // Digit count: top nonzero nibble position; 0 for value 0 at precision 0
  always_comb begin
    ndig_d = 4'd1;
    for (int i = 1; i < 8; i++) begin
      if (val_q[4*i +: 4] != 4'd0) ndig_d = 4'(i + 1);
    end
    if (hp_q && (prec_q == '0) && (val_q == 32'd0)) ndig_d = 4'd0;
  end

  // Field sizing terms for the setup and size states
  always_comb begin
    pre_d   = alt_q && (val_q != 32'd0);
    zeros_d = (hp_q && (prec_q > CW'(ndig_d))) ? prec_q - CW'(ndig_d) : '0;
    body_d  = (pre_d ? CW'(2) : '0) + zeros_d + CW'(ndig_d);
    pad_d   = (wid_q > body_q) ? wid_q - body_q : '0;
  end

  assign shift_nib = 4'd8 - ndig_q;

  // Character for the current phase
  always_comb begin
    emit_char = hff_pkg::CHAR_SPACE;
    case (state_q)
      hff_pkg::ST_PFX: begin
        if (cnt_q == CW'(2)) begin
          emit_char = hff_pkg::CHAR_ZERO;
        end else begin
          emit_char = upper_q ? hff_pkg::CHAR_X_UP : hff_pkg::CHAR_X_LO;
        end
      end
      hff_pkg::ST_ZPAD,
      hff_pkg::ST_ZERO:  emit_char = hff_pkg::CHAR_ZERO;
      hff_pkg::ST_DIGIT: emit_char = hff_pkg::hex_char(dig_q[31:28], upper_q);
      default:           emit_char = hff_pkg::CHAR_SPACE;
    endcase
  end

  // Sequencer: each output phase counts its segment down, then loads the next
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    dig_d    = dig_q;
    emit     = 1'b0;
    case (state_q)
      hff_pkg::ST_IDLE: begin
        if (in_acc) state_d = hff_pkg::ST_SETUP;
      end
      hff_pkg::ST_SETUP: begin
        state_d = hff_pkg::ST_SIZE;
      end
      hff_pkg::ST_SIZE: begin
        dig_d = val_q << {shift_nib, 2'b00};
        rem_d = (wid_q > body_q) ? wid_q : body_q;
        cnt_d = (!left_q && !zpad_eff) ? pad_d : '0;
        if ((wid_q == '0) && (body_q == '0)) begin
          state_d = hff_pkg::ST_IDLE;
        end else begin
          state_d = hff_pkg::ST_LEAD;
        end
      end
      hff_pkg::ST_LEAD,
      hff_pkg::ST_PFX,
      hff_pkg::ST_ZPAD,
      hff_pkg::ST_ZERO,
      hff_pkg::ST_DIGIT,
      hff_pkg::ST_TRAIL: begin
        if (cnt_q == '0) begin
          // segment done: move on and load the next segment length
          case (state_q)
            hff_pkg::ST_LEAD: begin
              state_d = hff_pkg::ST_PFX;
              cnt_d   = pre_q ? CW'(2) : '0;
            end
            hff_pkg::ST_PFX: begin
              state_d = hff_pkg::ST_ZPAD;
              cnt_d   = zpad_eff ? pad_q : '0;
            end
            hff_pkg::ST_ZPAD: begin
              state_d = hff_pkg::ST_ZERO;
              cnt_d   = zeros_q;
            end
            hff_pkg::ST_ZERO: begin
              state_d = hff_pkg::ST_DIGIT;
              cnt_d   = CW'(ndig_q);
            end
            hff_pkg::ST_DIGIT: begin
              state_d = hff_pkg::ST_TRAIL;
              cnt_d   = left_q ? pad_q : '0;
            end
            default: begin
              state_d = hff_pkg::ST_IDLE;
            end
          endcase
        end else if (out_free) begin
          emit  = 1'b1;
          cnt_d = cnt_q - CW'(1);
          rem_d = rem_q - CW'(1);
          if (state_q == hff_pkg::ST_DIGIT) dig_d = {dig_q[27:0], 4'd0};
          if (rem_q == CW'(1)) state_d = hff_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = hff_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_char_d  = emit_char;
      out_last_d  = (rem_q == CW'(1));
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hff_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    rem_q      <= rem_d;
    dig_q      <= dig_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    if (state_q == hff_pkg::ST_SETUP) begin
      ndig_q  <= ndig_d;
      pre_q   <= pre_d;
      zeros_q <= zeros_d;
      body_q  <= body_d;
    end
    if (state_q == hff_pkg::ST_SIZE) begin
      pad_q <= pad_d;
    end
  end

  assign in_stall_o  = (state_q != hff_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_char_o = out_last_q;

endmodule

@@ rtl/hff_checker.sv @@
// ----------------------------------------------------------------------------
// hff_checker
// Port-level checks for the hex field formatter, bound to the formatter module.
// ----------------------------------------------------------------------------
module hff_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [31:0] value_i,
  input logic        upper_case_i,
  input logic        alt_form_i,
  input logic        left_justify_i,
  input logic        zero_pad_i,
  input logic        has_precision_i,
  input logic [5:0]  precision_i,
  input logic [6:0]  field_width_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  out_char_o,
  input logic        last_char_o
);

  // An accepted request keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after request accepted");

  // A stalled character holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(out_char_o) && $stable(last_char_o)))
    else $error("stalled output changed");

  // Only digits, space and x/X ever leave the block
  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((out_char_o >= hff_pkg::CHAR_ZERO && out_char_o <= hff_pkg::CHAR_NINE) ||
       (out_char_o >= hff_pkg::CHAR_A_UP && out_char_o <= hff_pkg::CHAR_F_UP) ||
       (out_char_o >= hff_pkg::CHAR_A_LO && out_char_o <= hff_pkg::CHAR_F_LO) ||
       out_char_o == hff_pkg::CHAR_SPACE || out_char_o == hff_pkg::CHAR_X_UP ||
       out_char_o == hff_pkg::CHAR_X_LO))
    else $error("unexpected output character");

  // A character that is not the last means the field is still in progress
  a_mid_field_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_char_o) |-> in_stall_o)
    else $error("block idle in the middle of a field");

  // Idle with an empty output: no character can appear the next cycle
  a_no_spurious_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_stall_o && !out_valid_o) |=> !out_valid_o)
    else $error("character appeared without a request in progress");

endmodule

bind hex_field_formatter hff_checker u_hff_checker (.*);
